### hdl/lspd_pkg.sv
`default_nettype none
package lspd_pkg;

    localparam int unsigned MAX_FRAME_POINTS = 1024;
    localparam int unsigned FP_W = 11;
    localparam logic [FP_W-1:0] MIN_POINTS_RESET = 11'd400;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYNC1_MASK = 8'h11;
    localparam logic [7:0] SYNC1_VAL = 8'h10;
    localparam int unsigned LAST_POINT_BYTE = 4;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SECOND,
        PH_SKIP0,
        PH_SKIP1,
        PH_SKIP2,
        PH_ALIGNED
    } phase_t;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    // work for the back end, at most one entry per point-completing byte
    typedef enum logic [1:0] {
        CMD_POINT,        // single point
        CMD_END_START,    // frame end, then opening start point
        CMD_ABORT,        // abort only
        CMD_POINT_ABORT   // point, then overflow abort
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic             start_point;
        logic [5:0]       quality;
        logic [14:0]      angle_q6;
        logic [15:0]      distance_q2;
        logic [FP_W-1:0]  frame_points;
    } entry_t;

endpackage
`default_nettype wire

### hdl/lspd_front.sv
`default_nettype none
module lspd_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              rx_byte,
    input  wire logic                    cfg_valid,
    input  wire logic [lspd_pkg::FP_W-1:0] cfg_data,
    input  wire logic                    q_full,
    output logic                         q_push,
    output lspd_pkg::entry_t             q_entry
);
    import lspd_pkg::*;

    phase_t          phase_reg, phase_next;
    logic            open_reg, open_next;
    logic [2:0]      pos_reg, pos_next;
    logic [FP_W-1:0] count_reg, count_next;
    logic [FP_W-1:0] min_pts_reg;
    logic [7:0]      pb_reg [4];

    logic            accept;
    logic            is_start;
    logic [FP_W-1:0] count_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_start = pb_reg[0][0] && !pb_reg[0][1] && pb_reg[1][0];
    assign count_inc = count_reg + FP_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        open_next  = open_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        q_entry.cmd          = CMD_POINT;
        q_entry.start_point  = is_start;
        q_entry.quality      = pb_reg[0][7:2];
        q_entry.angle_q6     = {pb_reg[2], pb_reg[1][7:1]};
        q_entry.distance_q2  = {rx_byte, pb_reg[3]};
        q_entry.frame_points = count_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if ((rx_byte & SYNC1_MASK) == SYNC1_VAL)
                        phase_next = PH_SECOND;
                end
                PH_SECOND:
                begin
                    phase_next = rx_byte[0] ? PH_SKIP0 : PH_SEARCH;
                end
                PH_SKIP0:
                begin
                    phase_next = PH_SKIP1;
                end
                PH_SKIP1:
                begin
                    phase_next = PH_SKIP2;
                end
                PH_SKIP2:
                begin
                    phase_next = PH_ALIGNED;
                    pos_next   = 3'd0;
                    count_next = '0;
                end
                PH_ALIGNED:
                begin
                    if (pos_reg != 3'(LAST_POINT_BYTE))
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        pos_next = 3'd0;
                        if (!open_reg)
                        begin
                            if (is_start)
                            begin
                                q_push     = 1'b1;
                                open_next  = 1'b1;
                                count_next = FP_W'(1);
                            end
                        end
                        else if (is_start)
                        begin
                            q_push = 1'b1;
                            if (count_reg > min_pts_reg)
                            begin
                                q_entry.cmd = CMD_END_START;
                                count_next  = FP_W'(1);
                            end
                            else
                            begin
                                q_entry.cmd = CMD_ABORT;
                                open_next   = 1'b0;
                                phase_next  = PH_SEARCH;
                                count_next  = '0;
                            end
                        end
                        else
                        begin
                            q_push     = 1'b1;
                            count_next = count_inc;
                            if (count_inc >= FP_W'(MAX_FRAME_POINTS))
                            begin
                                q_entry.cmd = CMD_POINT_ABORT;
                                open_next   = 1'b0;
                                phase_next  = PH_SEARCH;
                                count_next  = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            open_reg    <= 1'b0;
            pos_reg     <= 3'd0;
            count_reg   <= '0;
            min_pts_reg <= MIN_POINTS_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            open_reg  <= open_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            if (cfg_valid)
                min_pts_reg <= cfg_data;
        end
    end

    // point byte capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_ALIGNED && pos_reg != 3'(LAST_POINT_BYTE))
            pb_reg[pos_reg[1:0]] <= rx_byte;
    end

endmodule
`default_nettype wire

### hdl/lspd_queue.sv
`default_nettype none
module lspd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lspd_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output lspd_pkg::entry_t       head
);
    import lspd_pkg::*;

    entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign full      = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

endmodule
`default_nettype wire

### hdl/lspd_back.sv
`default_nettype none
module lspd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_not_empty,
    input  wire lspd_pkg::entry_t  q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             out_kind,
    output logic                   out_start,
    output logic [5:0]             out_quality,
    output logic [14:0]            out_angle,
    output logic [15:0]            out_dist,
    output logic [lspd_pkg::FP_W-1:0] out_fp,
    output logic                   out_last
);
    import lspd_pkg::*;

    logic            valid_reg;
    logic            sub_reg, sub_next;
    logic            load;
    logic            two_results;

    logic [1:0]      kind_reg, kind_next;
    logic            start_reg, start_next;
    logic [5:0]      qual_reg, qual_next;
    logic [14:0]     angle_reg, angle_next;
    logic [15:0]     dist_reg, dist_next;
    logic [FP_W-1:0] fp_reg, fp_next;
    logic            last_reg, last_next;

    assign load        = q_not_empty && (!valid_reg || out_ready);
    assign two_results = q_head.cmd == CMD_END_START || q_head.cmd == CMD_POINT_ABORT;
    assign q_pop       = load && (!two_results || sub_reg);

    always_comb
    begin
        sub_next   = sub_reg;
        kind_next  = KIND_POINT;
        start_next = 1'b0;
        qual_next  = '0;
        angle_next = '0;
        dist_next  = '0;
        fp_next    = '0;
        last_next  = 1'b1;
        if (load)
            sub_next = two_results && !sub_reg;
        unique case (q_head.cmd)
            CMD_POINT:
            begin
                start_next = q_head.start_point;
                qual_next  = q_head.quality;
                angle_next = q_head.angle_q6;
                dist_next  = q_head.distance_q2;
            end
            CMD_END_START:
            begin
                if (!sub_reg)
                begin
                    kind_next = KIND_END;
                    fp_next   = q_head.frame_points;
                    last_next = 1'b0;
                end
                else
                begin
                    start_next = 1'b1;
                    qual_next  = q_head.quality;
                    angle_next = q_head.angle_q6;
                    dist_next  = q_head.distance_q2;
                end
            end
            CMD_ABORT:
            begin
                kind_next = KIND_ABORT;
            end
            CMD_POINT_ABORT:
            begin
                if (!sub_reg)
                begin
                    qual_next  = q_head.quality;
                    angle_next = q_head.angle_q6;
                    dist_next  = q_head.distance_q2;
                    last_next  = 1'b0;
                end
                else
                begin
                    kind_next = KIND_ABORT;
                end
            end
            default:
            begin
                kind_next = KIND_ABORT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            start_reg <= start_next;
            qual_reg  <= qual_next;
            angle_reg <= angle_next;
            dist_reg  <= dist_next;
            fp_reg    <= fp_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_start   = start_reg;
    assign out_quality = qual_reg;
    assign out_angle   = angle_reg;
    assign out_dist    = dist_reg;
    assign out_fp      = fp_reg;
    assign out_last    = last_reg;

endmodule
`default_nettype wire

### hdl/lidar_scan_point_deframer.sv
// Scan point deframer for a laser scanner's 5-byte measurement stream.
// s_* : one received link byte per transfer (s_tdata[7:0]).
// cfg_* : write of min_frame_points; always ready, takes effect next cycle.
// m_* : results. m_tuser = {start_point, kind}, m_tdata = {frame_points,
//   distance_q2, angle_q6, quality}, m_tlast marks the last result of a byte.
//   kind: 0 point, 1 frame end (with point count), 2 frame abort.
// Throughput: one byte per cycle unless the queue is full. Only every fifth
// aligned byte may yield results (one or two), so output keeps up at full rate.
// The queue is written on the edge that takes the byte completing a point;
// the output register then loads the head when empty or when m_tready is high.
// A closing start point that ends a frame yields two results, frame end first.
// Stall: the 4-entry command queue absorbs output backpressure; s_tready
// drops only when the queue is full.
// Reset: search for alignment, no frame open, queue and output empty,
// min_frame_points = 400.
`default_nettype none
module lidar_scan_point_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data,  // min_frame_points
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [5:0] quality, [20:6] angle_q6,
                                        // [36:21] distance_q2, [47:37] frame_points
    output logic [2:0]       m_tuser,   // [1:0] kind, [2] start_point
    output logic             m_tlast
);
    import lspd_pkg::*;

    logic            q_full, q_push, q_pop, q_not_empty;
    entry_t          q_entry, q_head;

    logic [1:0]      r_kind;
    logic            r_start;
    logic [5:0]      r_quality;
    logic [14:0]     r_angle;
    logic [15:0]     r_dist;
    logic [FP_W-1:0] r_fp;

    assign cfg_ready = 1'b1;

    // front: alignment, point assembly, frame tracking
    lspd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .rx_byte   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // decouples byte intake from result delivery
    lspd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // back: expands each command into one or two results
    lspd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (r_kind),
        .out_start   (r_start),
        .out_quality (r_quality),
        .out_angle   (r_angle),
        .out_dist    (r_dist),
        .out_fp      (r_fp),
        .out_last    (m_tlast)
    );

    assign m_tdata = {r_fp, r_dist, r_angle, r_quality};
    assign m_tuser = {r_start, r_kind};

endmodule
`default_nettype wire

### tb/sv/scan_point_checker.sv
`default_nettype none
// Watches the three channels of the deframer, tracks its state byte by byte
// and compares every result transfer with the oldest awaited one.
module scan_point_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] rx_byte
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [lspd_pkg::FP_W-1:0] cfg_data,  // min_frame_points
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [47:0]               m_tdata,   // [5:0] quality, [20:6] angle_q6,
                                                      // [36:21] distance_q2,
                                                      // [47:37] frame_points
    input  wire logic [2:0]                m_tuser,   // [1:0] kind, [2] start_point
    input  wire logic                      m_tlast,
    output int unsigned                    fail_count,
    output int unsigned                    pending,
    output int unsigned                    points_seen,
    output int unsigned                    ends_seen,
    output int unsigned                    aborts_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import lspd_pkg::*;

    typedef struct {
        kind_t           kind;
        logic            start_point;
        logic [5:0]      quality;
        logic [14:0]     angle_q6;
        logic [15:0]     distance_q2;
        logic [FP_W-1:0] frame_points;
        logic            last;
    } scan_result_t;

    logic [FP_W-1:0] min_points;
    phase_t          phase;
    logic            in_frame;
    logic [2:0]      byte_pos;
    logic [7:0]      held [4];
    logic [FP_W-1:0] point_cnt;
    scan_result_t    awaited_results [$];
    int unsigned     checked;

    function automatic scan_result_t make_result(kind_t k, logic st, logic [5:0] q,
                                                 logic [14:0] a, logic [15:0] d,
                                                 logic [FP_W-1:0] fp);
        scan_result_t r;
        r.kind         = k;
        r.start_point  = st;
        r.quality      = q;
        r.angle_q6     = a;
        r.distance_q2  = d;
        r.frame_points = fp;
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                    checked, name, got, want));
    endtask

    task automatic restart_search();
        in_frame  = 1'b0;
        phase     = PH_SEARCH;
        byte_pos  = '0;
        point_cnt = '0;
    endtask

    // advance the tracked state by one link byte, queue what it produces
    task automatic deframe_byte(input logic [7:0] b);
        logic         st;
        scan_result_t pt;
        scan_result_t made [$];
        case (phase)
            PH_SEARCH: if ((b & SYNC1_MASK) == SYNC1_VAL) phase = PH_SECOND;
            PH_SECOND: phase = b[0] ? PH_SKIP0 : PH_SEARCH;
            PH_SKIP0:  phase = PH_SKIP1;
            PH_SKIP1:  phase = PH_SKIP2;
            PH_SKIP2:
            begin
                phase     = PH_ALIGNED;
                byte_pos  = '0;
                point_cnt = '0;
            end
            default:
            begin
                if (byte_pos < LAST_POINT_BYTE)
                begin
                    held[byte_pos[1:0]] = b;
                    byte_pos++;
                end
                else
                begin
                    byte_pos = '0;
                    st = held[0][0] && !held[0][1] && held[1][0];
                    pt = make_result(KIND_POINT, st, held[0][7:2],
                                     {held[2], held[1][7:1]}, {b, held[3]}, '0);
                    if (!in_frame)
                    begin
                        if (st)
                        begin
                            in_frame  = 1'b1;
                            point_cnt = 1;
                            made.push_back(pt);
                        end
                    end
                    else if (st)
                    begin
                        if (point_cnt > min_points)
                        begin
                            made.push_back(make_result(KIND_END, 0, 0, 0, 0, point_cnt));
                            made.push_back(pt);
                            point_cnt = 1;
                        end
                        else
                        begin
                            made.push_back(make_result(KIND_ABORT, 0, 0, 0, 0, 0));
                            restart_search();
                        end
                    end
                    else
                    begin
                        made.push_back(pt);
                        point_cnt++;
                        if (point_cnt >= MAX_FRAME_POINTS)
                        begin
                            made.push_back(make_result(KIND_ABORT, 0, 0, 0, 0, 0));
                            restart_search();
                        end
                    end
                end
            end
        endcase
        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
        foreach (made[i])
            awaited_results.push_back(made[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t want;
        if (!rst_n)
        begin
            min_points  = MIN_POINTS_RESET;
            restart_search();
            awaited_results.delete();
            checked     = 0;
            fail_count  = 0;
            points_seen = 0;
            ends_seen   = 0;
            aborts_seen = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                min_points = cfg_data;
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch($sformatf("result %0d arrived with none awaited", checked));
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", m_tuser[1:0], want.kind);
                    check_field("start_point", m_tuser[2], want.start_point);
                    check_field("quality", m_tdata[5:0], want.quality);
                    check_field("angle_q6", m_tdata[20:6], want.angle_q6);
                    check_field("distance_q2", m_tdata[36:21], want.distance_q2);
                    check_field("frame_points", m_tdata[47:37], want.frame_points);
                    check_field("last", m_tlast, want.last);
                    case (want.kind)
                        KIND_POINT: points_seen++;
                        KIND_END:   ends_seen++;
                        default:    aborts_seen++;
                    endcase
                end
                checked++;
            end
            pending <= awaited_results.size();
        end
    end

endmodule
`default_nettype wire

### tb/sv/lidar_scan_point_deframer_test.sv
`default_nettype none
// Stimulus and verdict for the scan point deframer. All prediction and
// comparison lives in scan_point_checker; this module only produces link
// bytes, config writes and output backpressure.
module lidar_scan_point_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lspd_pkg::*;

    localparam int unsigned IDLE_PCT      = 21;        // idle cycles per hundred
    localparam int unsigned SETTLE_CYCLES = 8;         // extra wait after the checker queue drains
    localparam int unsigned RUN_LIMIT_NS  = 2_000_000; // hard stop for a hung run

    // how a generated point is built
    typedef enum {
        FORM_PLAIN,   // never passes the start point test
        FORM_START,   // always passes it
        FORM_RANDOM   // all five bytes random
    } point_form_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [7:0]      s_tdata;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [FP_W-1:0] cfg_data;
    logic            m_tvalid;
    logic            m_tready;
    logic [47:0]     m_tdata;
    logic [2:0]      m_tuser;
    logic            m_tlast;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned points_seen;
    int unsigned ends_seen;
    int unsigned aborts_seen;

    // Stimulus-side view of the link. Kept exact by only sending noise that
    // cannot move the block to an alignment state we do not know about.
    bit          aligned;
    bit          in_frame;
    int unsigned point_cnt;
    int unsigned min_now;
    int unsigned bytes_sent;
    int unsigned settings_used;
    bit          calm;       // suppresses idling on both sides

    lidar_scan_point_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    scan_point_checker i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .points_seen (points_seen),
        .ends_seen   (ends_seen),
        .aborts_seen (aborts_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side backpressure, re-rolled every cycle
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // One byte transfer. Returns right after the accepting edge with s_tvalid
    // still high, so the next call can keep the stream going without a bubble.
    task automatic send_byte(input logic [7:0] b);
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Drop s_tvalid, wait until every awaited result has come out, then wait on
    // so that bytes that produce nothing can pass through the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min(input logic [FP_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        min_now = v;
        settings_used++;
    endtask

    // five point bytes; the link view follows the frame rules
    task automatic send_point(input point_form_t form);
        logic [7:0] pb [5];
        logic       st;
        foreach (pb[i])
            pb[i] = $urandom;
        case (form)
            FORM_START:
            begin
                pb[0][1:0] = 2'b01;
                pb[1][0]   = 1'b1;
            end
            FORM_PLAIN:
                // break the start test either through quality or through angle
                if (pb[0][0] && !pb[0][1] && pb[1][0])
                begin
                    if ($urandom_range(0, 1))
                        pb[1][0] = 1'b0;
                    else
                        pb[0][1] = 1'b1;
                end
            default: ;
        endcase
        st = pb[0][0] && !pb[0][1] && pb[1][0];
        foreach (pb[i])
            send_byte(pb[i]);
        if (!in_frame)
        begin
            if (st)
            begin
                in_frame  = 1'b1;
                point_cnt = 1;
            end
        end
        else if (st)
        begin
            if (point_cnt > min_now)
                point_cnt = 1;
            else
            begin
                aligned  = 1'b0;
                in_frame = 1'b0;
            end
        end
        else
        begin
            point_cnt++;
            if (point_cnt >= MAX_FRAME_POINTS)
            begin
                aligned  = 1'b0;
                in_frame = 1'b0;
            end
        end
    endtask

    // One random step of the link. Mostly well-formed headers and points;
    // the rest is search-state junk, broken headers and dropped points.
    task automatic link_step(input int unsigned close_pct);
        int unsigned r;
        logic [7:0]  junk;
        r = $urandom_range(0, 99);
        if (!aligned)
        begin
            if (r < 15)
                repeat ($urandom_range(1, 4))
                begin
                    junk = $urandom;
                    if ((junk & SYNC1_MASK) == SYNC1_VAL)
                        junk[0] = 1'b1;
                    send_byte(junk);
                end
            else
            begin
                junk    = $urandom;
                junk[4] = 1'b1;
                junk[0] = 1'b0;
                send_byte(junk);
                // second byte with bit0 clear sends the block back to search
                junk    = $urandom;
                junk[0] = (r >= 25);
                send_byte(junk);
                if (r >= 25)
                begin
                    repeat (3) send_byte($urandom);
                    aligned   = 1'b1;
                    in_frame  = 1'b0;
                    point_cnt = 0;
                end
            end
        end
        else if (!in_frame)
            send_point(r < 20 ? FORM_PLAIN : (r < 30 ? FORM_RANDOM : FORM_START));
        else
            send_point(r < close_pct ? FORM_START
                     : (r < close_pct + 10 ? FORM_RANDOM : FORM_PLAIN));
    endtask

    task automatic run_bytes(input int unsigned count, input int unsigned close_pct);
        int unsigned stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            link_step(close_pct);
    endtask

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("lidar_scan_point_deframer test failed");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        m_tready  = 1'b0;
        calm      = 1'b0;
        aligned   = 1'b0;
        in_frame  = 1'b0;
        point_cnt = 0;
        min_now   = MIN_POINTS_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset threshold of 400 ---
        send_byte(8'h00);   // search: no sync
        send_byte(8'hFF);   // bit0 set, not a sync byte
        send_byte(8'h10);   // sync
        send_byte(8'h00);   // second byte fails, search again
        send_byte(8'hFE);   // sync
        send_byte(8'h01);   // second byte ok
        send_byte(8'h00);   // three skipped bytes
        send_byte(8'hFF);
        send_byte(8'h5A);
        // outside a frame: angle bit0 clear, dropped
        send_byte(8'h01); send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'hFF);
        // outside a frame: quality bit1 set, dropped
        send_byte(8'h03); send_byte(8'h01); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00);
        // start point with every field at its top value opens the frame
        send_byte(8'hFD); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'hFF);
        // all-zero point inside the frame
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00);
        aligned   = 1'b1;
        in_frame  = 1'b1;
        point_cnt = 2;

        // closing start point on a two-point frame is too short: abort
        send_point(FORM_START);

        // --- random phases across thresholds ---
        write_min(0);
        run_bytes(80, 35);

        write_min(1023);    // nothing short can end normally here
        run_bytes(50, 30);

        write_min($urandom_range(2, 6));
        calm = 1'b1;
        run_bytes(80, 25);
        calm = 1'b0;
        run_bytes(40, 25);
        settle();           // sender holds off until the output side is empty
        run_bytes(60, 25);

        // threshold of 1024: every closing start point aborts
        write_min(1024);
        run_bytes(30, 40);

        write_min(1);
        run_bytes(50, 30);

        settle();
        $display("sent %0d link bytes under %0d threshold settings",
                 bytes_sent, settings_used);
        $display("checked %0d points, %0d frame ends, %0d aborts",
                 points_seen, ends_seen, aborts_seen);
        if (fail_count == 0)
            $display("lidar_scan_point_deframer test passed");
        else
            $display("lidar_scan_point_deframer test failed");
        $finish;
    end

endmodule
`default_nettype wire
